[hw/rtl/cdm_pkg.sv]
// shared constants, types and the ratio factor table for the clock divider/multiplier
// used by every module under hw/rtl; depends on nothing
package cdm_pkg;

	// tick counter and period width
	localparam int unsigned TICK_W = 24;
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
	localparam logic [TICK_W-1:0] PERIOD_RESET = TICK_W'(24000);

	// configuration registers
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = CFG_IDX_W'(1);

	localparam int unsigned RATIO_W = 4;
	localparam int unsigned MINP_W = 16;
	localparam logic [RATIO_W-1:0] RATIO_PASS = RATIO_W'(5);
	localparam logic [RATIO_W-1:0] RATIO_LAST = RATIO_W'(10);
	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_PASS;
	localparam logic [MINP_W-1:0] MINP_RESET = MINP_W'(48);
	localparam logic [MINP_W-1:0] MINP_FLOOR = MINP_W'(8);

	// stream payload widths
	localparam int unsigned DATA_W = 8;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned DIV_W = 3;

	// configuration state seen by the core
	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic [MINP_W-1:0]  min_period;
		logic               ratio_wr;
	} cfg_t;

	// divide or multiply factor for a clamped ratio index
	function automatic logic [CNT_W-1:0] ratio_factor(input logic [RATIO_W-1:0] idx);
		logic [CNT_W-1:0] f;
		unique case (idx)
			4'd0:    f = 4'd8;
			4'd1:    f = 4'd6;
			4'd2:    f = 4'd4;
			4'd3:    f = 4'd3;
			4'd4:    f = 4'd2;
			4'd5:    f = 4'd1;
			4'd6:    f = 4'd2;
			4'd7:    f = 4'd3;
			4'd8:    f = 4'd4;
			4'd9:    f = 4'd6;
			default: f = 4'd8;
		endcase
		return f;
	endfunction

endpackage

[hw/rtl/cdm_cfg.sv]
// configuration registers: ratio index and minimum period
// depends on cdm_pkg
module cdm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cdm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cdm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output cdm_pkg::cfg_t                   cfg
);

	logic [cdm_pkg::RATIO_W-1:0] ratio_q;
	logic [cdm_pkg::MINP_W-1:0]  min_period_q;
	logic [cdm_pkg::RATIO_W-1:0] ratio_wr_val;
	logic                        ratio_wr;

	// out-of-range ratios clamp to the last entry
	assign ratio_wr_val = (cfg_wdata[cdm_pkg::RATIO_W-1:0] > cdm_pkg::RATIO_LAST) ?
		cdm_pkg::RATIO_LAST : cfg_wdata[cdm_pkg::RATIO_W-1:0];
	assign ratio_wr = cfg_we && (cfg_index == cdm_pkg::REG_RATIO);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q      <= cdm_pkg::RATIO_RESET;
			min_period_q <= cdm_pkg::MINP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cdm_pkg::REG_RATIO:      ratio_q <= ratio_wr_val;
				cdm_pkg::REG_MIN_PERIOD: min_period_q <= cfg_wdata[cdm_pkg::MINP_W-1:0];
				default: ;
			endcase
		end
	end

	// a minimum below the floor reads as the floor
	assign cfg.ratio      = ratio_q;
	assign cfg.min_period = (min_period_q < cdm_pkg::MINP_FLOOR) ?
		cdm_pkg::MINP_FLOOR : min_period_q;
	assign cfg.ratio_wr   = ratio_wr;

endmodule

[hw/rtl/cdm_core.sv]
// edge detection, period tracking and divide/multiply decision for one tick
// depends on cdm_pkg
module cdm_core (
	input  logic          clk,
	input  logic          arst_n,
	input  cdm_pkg::cfg_t cfg,
	input  logic          step,
	input  logic          clock_level,
	input  logic          reset_level,
	output logic          advance,
	output logic          clock_edge
);

	localparam int unsigned PROD_W = cdm_pkg::TICK_W + cdm_pkg::CNT_W;

	logic                          clock_prev_q;
	logic                          reset_prev_q;
	logic [cdm_pkg::DIV_W-1:0]     divide_count_q;
	logic [cdm_pkg::TICK_W-1:0]    ticks_q;
	logic [cdm_pkg::TICK_W-1:0]    period_q;
	logic [cdm_pkg::CNT_W-1:0]     fired_q;

	logic                          rst_edge;
	logic [cdm_pkg::DIV_W-1:0]     dc0;
	logic [cdm_pkg::TICK_W-1:0]    t0;
	logic [cdm_pkg::TICK_W-1:0]    t1;
	logic [cdm_pkg::CNT_W-1:0]     mf1;
	logic [cdm_pkg::TICK_W-1:0]    period_n;
	logic [cdm_pkg::DIV_W-1:0]     dc_n;
	logic [cdm_pkg::CNT_W-1:0]     mf_n;
	logic [cdm_pkg::CNT_W-1:0]     factor;
	logic [cdm_pkg::CNT_W-1:0]     dc_inc;
	logic [PROD_W-1:0]             due;
	logic [PROD_W-1:0]             next_mark;
	logic                          adv;

	assign factor = cdm_pkg::ratio_factor(cfg.ratio);

	// rising edges against the previous tick
	assign clock_edge = clock_level && !clock_prev_q;
	assign rst_edge   = reset_level && !reset_prev_q;

	// reset edge clears counters first
	assign dc0 = rst_edge ? '0 : divide_count_q;
	assign t0  = rst_edge ? '0 : ticks_q;

	// period capture and saturating tick count
	always_comb begin
		period_n = period_q;
		if (clock_edge) begin
			if (t0 > {{(cdm_pkg::TICK_W-cdm_pkg::MINP_W){1'b0}}, cfg.min_period})
				period_n = t0;
			t1  = '0;
			mf1 = '0;
		end else begin
			t1  = (t0 != cdm_pkg::TICK_MAX) ? t0 + 1'b1 : t0;
			mf1 = rst_edge ? '0 : fired_q;
		end
	end

	// multiply schedule products
	assign due       = PROD_W'(t1) * PROD_W'(factor);
	assign next_mark = PROD_W'(mf1) * PROD_W'(period_q);
	assign dc_inc    = {1'b0, dc0} + 1'b1;

	// mode decision
	always_comb begin
		adv  = 1'b0;
		dc_n = dc0;
		mf_n = mf1;
		if (cfg.ratio < cdm_pkg::RATIO_PASS) begin
			if (clock_edge) begin
				if (dc_inc >= factor) begin
					dc_n = '0;
					adv  = 1'b1;
				end else begin
					dc_n = dc_inc[cdm_pkg::DIV_W-1:0];
				end
			end
		end else if (cfg.ratio == cdm_pkg::RATIO_PASS) begin
			adv = clock_edge;
		end else begin
			if (clock_edge) begin
				adv  = 1'b1;
				mf_n = cdm_pkg::CNT_W'(1);
			end else if ((mf1 < factor) && (next_mark <= due)) begin
				adv  = 1'b1;
				mf_n = mf1 + 1'b1;
			end
		end
	end

	assign advance = adv;

	// tick state; a ratio write clears the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_prev_q   <= 1'b0;
			reset_prev_q   <= 1'b0;
			divide_count_q <= '0;
			ticks_q        <= '0;
			period_q       <= cdm_pkg::PERIOD_RESET;
			fired_q        <= '0;
		end else if (cfg.ratio_wr) begin
			divide_count_q <= '0;
			ticks_q        <= '0;
			fired_q        <= '0;
		end else if (step) begin
			clock_prev_q   <= clock_level;
			reset_prev_q   <= reset_level;
			divide_count_q <= dc_n;
			ticks_q        <= t1;
			period_q       <= period_n;
			fired_q        <= mf_n;
		end
	end

endmodule

[hw/rtl/clock_divider_multiplier_unit.sv]
// Clock divider/multiplier top level: input register, tick core, result register.
// Path: an accepted item goes through the input register, then the result register.
// Throughput: one item per cycle while results are taken; a stalled result holds both stages.
// Reset (arst_n low): ratio pass-through, minimum period 48, counters zero,
// period 24000 ticks, both stages empty.
// depends on cdm_pkg, cdm_cfg, cdm_core
module clock_divider_multiplier_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cdm_pkg::DATA_W-1:0]      s_tdata,   // [0] clock_level, [1] reset_level
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cdm_pkg::DATA_W-1:0]      m_tdata,   // [0] advance, [1] clock_edge
	input  logic                            cfg_we,
	input  logic [cdm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cdm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	cdm_pkg::cfg_t cfg;

	logic valid_s1;
	logic clock_s1;
	logic reset_s1;
	logic out_valid_q;
	logic advance_q;
	logic edge_q;
	logic step;
	logic advance;
	logic clock_edge;

	// stage 1 moves when the result register is free or being drained
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	cdm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cdm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (step),
		.clock_level (clock_s1),
		.reset_level (reset_s1),
		.advance     (advance),
		.clock_edge  (clock_edge)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			clock_s1 <= s_tdata[0];
			reset_s1 <= s_tdata[1];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			advance_q <= advance;
			edge_q    <= clock_edge;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(cdm_pkg::DATA_W-2){1'b0}}, edge_q, advance_q};

endmodule

[hw/rtl/cdm_checker.sv]
// port-level checks for the clock divider/multiplier, bound to the top level
// depends on cdm_pkg and clock_divider_multiplier_unit
module cdm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [cdm_pkg::DATA_W-1:0]  m_tdata
);

	logic       in_fire;
	logic       out_fire;
	logic [1:0] inflight_q;
	logic       last_edge_q;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	// items held in the two stages, and clock_edge of the last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q  <= '0;
			last_edge_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + {1'b0, in_fire} - {1'b0, out_fire};
			if (out_fire)
				last_edge_q <= m_tdata[1];
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no result without an item behind it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> inflight_q != 2'd0)
		else $error("result without item");

	// at most two items inside
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !out_fire |-> inflight_q != 2'd2)
		else $error("more than two items inside");

	// no rising clock edge on two consecutive results
	a_edge_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && last_edge_q |-> !m_tdata[1])
		else $error("clock edge on consecutive items");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[cdm_pkg::DATA_W-1:2] == '0)
		else $error("nonzero padding in result");

endmodule

bind clock_divider_multiplier_unit cdm_checker u_cdm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
